>>> rtl/mglf_pkg.sv
// ----------------------------------------------------------------------------
// mglf_pkg: shared types and constants of the masked gap linear fill block
// Widths, limits, controller states and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mglf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 12;
  localparam int ROW_WIDTH  = 4096;
  localparam int MAX_GAP    = 63;
  localparam int GAP_W      = $clog2(MAX_GAP + 1);
  // A run may cover a whole row, so its length needs one bit more than a position.
  localparam int RUN_W      = $clog2(ROW_WIDTH) + 1;
  localparam int TWOC_W     = RUN_W + 1;
  localparam int FRAC_W     = 16;
  localparam int WT_W       = FRAC_W + 1;
  localparam int DIV_STEPS  = WT_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = WT_W + DIFF_W + 1;
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + POS_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [WT_W-1:0]   WT_ONE    = WT_W'(1) << FRAC_W;
  localparam logic [POS_W-1:0]  ROW_LAST  = POS_W'(ROW_WIDTH - 1);
  localparam logic [GAP_W-1:0]  GAP_LIMIT = GAP_W'(MAX_GAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_STEP,
    S_MUL,
    S_FOUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic step;
    logic mul;
    logic load_fill;
    logic load_item;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic emit;
    logic div_done;
    logic fill_last;
    logic slot_free;
  } status_t;

endpackage

>>> rtl/mglf_div.sv
// ----------------------------------------------------------------------------
// mglf_div: per-run reciprocal divider
// Restoring divider that forms 2^16 / divisor, one quotient bit per cycle,
// and reports the quotient and the remainder.
// ----------------------------------------------------------------------------
module mglf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mglf_pkg::RUN_W-1:0]   divisor,
  output logic                         done,
  output logic [mglf_pkg::WT_W-1:0]    quo,
  output logic [mglf_pkg::RUN_W-1:0]   rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [mglf_pkg::DCNT_W-1:0]   cnt_r;
  logic [mglf_pkg::RUN_W-1:0]    dvs_r;
  logic [mglf_pkg::RUN_W-1:0]    rem_r;
  logic [mglf_pkg::WT_W-1:0]     quo_r;
  logic [mglf_pkg::RUN_W:0]      trial;
  logic                          fits;

  // The dividend is a single one at the top bit, shifted in on the first step.
  assign trial = {rem_r, (cnt_r == mglf_pkg::DCNT_W'(mglf_pkg::DIV_STEPS))};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= mglf_pkg::DCNT_W'(mglf_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - mglf_pkg::DCNT_W'(1);
      busy_r <= (cnt_r != mglf_pkg::DCNT_W'(1));
      done_r <= (cnt_r == mglf_pkg::DCNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? mglf_pkg::RUN_W'(trial - {1'b0, dvs_r})
                    : mglf_pkg::RUN_W'(trial);
      quo_r <= {quo_r[mglf_pkg::WT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> rtl/mglf_ctrl.sv
// ----------------------------------------------------------------------------
// mglf_ctrl: sequencing controller
// Takes one input transaction at a time and walks it through evaluation and,
// where it needs them, the reciprocal division, the per-sample fill loop and the final emit.
// ----------------------------------------------------------------------------
module mglf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  mglf_pkg::status_t    status,
  output mglf_pkg::cmd_t       cmd
);

  mglf_pkg::state_t state_r;
  mglf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mglf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mglf_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mglf_pkg::S_EVAL;
      end
      mglf_pkg::S_EVAL: begin
        if (status.flush) begin
          state_nxt = mglf_pkg::S_DIV;
        end else if (status.emit) begin
          state_nxt = mglf_pkg::S_EMIT;
        end else begin
          state_nxt = mglf_pkg::S_IDLE;
        end
      end
      mglf_pkg::S_DIV: begin
        if (status.div_done) state_nxt = mglf_pkg::S_STEP;
      end
      mglf_pkg::S_STEP: state_nxt = mglf_pkg::S_MUL;
      mglf_pkg::S_MUL:  state_nxt = mglf_pkg::S_FOUT;
      mglf_pkg::S_FOUT: begin
        if (status.slot_free) begin
          if (!status.fill_last) begin
            state_nxt = mglf_pkg::S_STEP;
          end else if (status.emit) begin
            state_nxt = mglf_pkg::S_EMIT;
          end else begin
            state_nxt = mglf_pkg::S_IDLE;
          end
        end
      end
      mglf_pkg::S_EMIT: begin
        if (status.slot_free) state_nxt = mglf_pkg::S_IDLE;
      end
      default: state_nxt = mglf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == mglf_pkg::S_IDLE);
    cmd       = '0;
    unique case (state_r)
      mglf_pkg::S_IDLE: cmd.capture = in_tvalid;
      mglf_pkg::S_EVAL: begin
        cmd.div_start = status.flush;
        cmd.finish    = !status.flush && !status.emit;
      end
      mglf_pkg::S_DIV:  cmd = '0;
      mglf_pkg::S_STEP: cmd.step = 1'b1;
      mglf_pkg::S_MUL:  cmd.mul  = 1'b1;
      mglf_pkg::S_FOUT: begin
        cmd.load_fill = status.slot_free;
        cmd.finish    = status.slot_free && status.fill_last && !status.emit;
      end
      mglf_pkg::S_EMIT: begin
        cmd.load_item = status.slot_free;
        cmd.finish    = status.slot_free;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == mglf_pkg::S_IDLE)
    else $error("item finished but controller did not return to idle");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_fill, cmd.load_item, cmd.capture}))
    else $error("output register loaded from two sources at once");

  a_div_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> $past(state_r) == mglf_pkg::S_IDLE)
    else $error("division started outside evaluation of a fresh item");

  a_fill_needs_flush: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mglf_pkg::S_STEP |-> status.flush)
    else $error("fill step without a run to flush");
`endif

endmodule

>>> rtl/mglf_dp.sv
// ----------------------------------------------------------------------------
// mglf_dp: datapath of the gap fill
// Holds the row state, the captured item, the incremental weight generator,
// the blend multiplier and the output register.
// ----------------------------------------------------------------------------
module mglf_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mglf_pkg::cmd_t                          cmd,
  output mglf_pkg::status_t                       status,
  input  logic signed [mglf_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                                    in_masked,
  input  logic                                    in_row_end,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mglf_pkg::SAMPLE_W-1:0]    out_value,
  output logic [mglf_pkg::POS_W-1:0]              out_position,
  output logic                                    out_filled,
  output logic                                    out_unfilled,
  output logic                                    out_last
);

  // Row state.
  logic signed [mglf_pkg::SAMPLE_W-1:0] left_r;
  logic [mglf_pkg::GAP_W-1:0]           gap_r;
  logic [mglf_pkg::POS_W-1:0]           gstart_r;
  logic [mglf_pkg::POS_W-1:0]           rowpos_r;
  logic [mglf_pkg::RUN_W-1:0]           run_r;

  // Captured item.
  logic signed [mglf_pkg::SAMPLE_W-1:0] smp_r;
  logic signed [mglf_pkg::SAMPLE_W-1:0] right_r;
  logic                                 masked_r;
  logic                                 end_r;
  logic                                 ovf_r;

  // Fill loop.
  logic [mglf_pkg::WT_W-1:0]            wq_r;
  logic [mglf_pkg::TWOC_W-1:0]          wr_r;
  logic [mglf_pkg::TWOC_W-1:0]          twoc_r;
  logic [mglf_pkg::GAP_W-1:0]           m_r;
  logic signed [mglf_pkg::PROD_W-1:0]   prod_r;

  // Output register.
  logic                                 oval_r;
  logic signed [mglf_pkg::SAMPLE_W-1:0] oval_data_r;
  logic [mglf_pkg::POS_W-1:0]           opos_r;
  logic                                 ofill_r;
  logic                                 ounf_r;
  logic                                 olast_r;

  logic                                 item_end;
  logic                                 gap_full;
  logic [mglf_pkg::RUN_W-1:0]           count;
  logic                                 div_done;
  logic [mglf_pkg::WT_W-1:0]            q0;
  logic [mglf_pkg::RUN_W-1:0]           div_rem;
  logic [mglf_pkg::TWOC_W-1:0]          r0;
  logic [mglf_pkg::TWOC_W:0]            r_sub;
  logic                                 borrow;
  logic signed [mglf_pkg::DIFF_W-1:0]   diff;
  logic signed [mglf_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [mglf_pkg::PROD_W-1:0]   prod_rnd;
  logic signed [mglf_pkg::SAMPLE_W-1:0] fill_value;
  logic                                 fill_last;

  assign item_end = in_row_end || (rowpos_r == mglf_pkg::ROW_LAST);
  assign gap_full = (gap_r >= mglf_pkg::GAP_LIMIT);
  assign count    = run_r + mglf_pkg::RUN_W'(1);

  mglf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (count),
    .done    (div_done),
    .quo     (q0),
    .rem     (div_rem)
  );

  // The left weight is floor((2^17*l + c) / 2c). Stepping l down by one takes
  // 2^17 / 2c off the quotient, with one borrow correction of the remainder.
  assign r0     = {div_rem, 1'b0};
  assign r_sub  = {1'b0, wr_r} - {1'b0, r0};
  assign borrow = r_sub[mglf_pkg::TWOC_W];

  assign diff     = mglf_pkg::DIFF_W'(left_r) - mglf_pkg::DIFF_W'(right_r);
  assign prod_nxt = mglf_pkg::PROD_W'($signed({1'b0, wq_r})) * mglf_pkg::PROD_W'(diff);
  assign prod_rnd = prod_r + (mglf_pkg::PROD_W'(1) <<< (mglf_pkg::FRAC_W - 1));
  assign fill_value = right_r
    + prod_rnd[mglf_pkg::FRAC_W +: mglf_pkg::SAMPLE_W];

  assign fill_last = ({1'b0, m_r} + (mglf_pkg::GAP_W + 1)'(1)) == {1'b0, gap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      gap_r    <= '0;
      gstart_r <= '0;
      rowpos_r <= '0;
      run_r    <= '0;
    end else if (cmd.capture) begin
      if (in_masked) begin
        if (run_r == '0) gstart_r <= rowpos_r;
        run_r <= run_r + mglf_pkg::RUN_W'(1);
        if (!gap_full) gap_r <= gap_r + mglf_pkg::GAP_W'(1);
      end
    end else if (cmd.finish) begin
      if (end_r) begin
        left_r   <= '0;
        gap_r    <= '0;
        gstart_r <= '0;
        rowpos_r <= '0;
        run_r    <= '0;
      end else begin
        if (!masked_r) left_r <= smp_r;
        if (status.flush) begin
          gap_r <= '0;
          run_r <= '0;
        end
        rowpos_r <= rowpos_r + mglf_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r    <= in_sample;
      right_r  <= in_masked ? '0 : in_sample;
      masked_r <= in_masked;
      end_r    <= item_end;
      ovf_r    <= in_masked && gap_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // Start one step above the first sample: l = c gives q = 2^16, r = c.
      wq_r   <= mglf_pkg::WT_ONE;
      wr_r   <= mglf_pkg::TWOC_W'(count);
      twoc_r <= {count, 1'b0};
      m_r    <= '0;
    end else begin
      if (cmd.step) begin
        wr_r <= borrow ? r_sub[mglf_pkg::TWOC_W-1:0] + twoc_r
                       : r_sub[mglf_pkg::TWOC_W-1:0];
        wq_r <= wq_r - q0 - mglf_pkg::WT_W'(borrow);
      end
      if (cmd.load_fill) m_r <= m_r + mglf_pkg::GAP_W'(1);
    end
    if (cmd.mul) prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.load_fill || cmd.load_item) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fill) begin
      oval_data_r <= fill_value;
      opos_r      <= gstart_r + mglf_pkg::POS_W'(m_r);
      ofill_r     <= 1'b1;
      ounf_r      <= 1'b0;
      olast_r     <= fill_last && !status.emit;
    end else if (cmd.load_item) begin
      oval_data_r <= masked_r ? '0 : smp_r;
      opos_r      <= rowpos_r;
      ofill_r     <= 1'b0;
      ounf_r      <= masked_r;
      olast_r     <= 1'b1;
    end
  end

  always_comb begin
    status.flush     = (masked_r && end_r) || (!masked_r && (run_r != '0));
    status.emit      = !masked_r || ovf_r;
    status.div_done  = div_done;
    status.fill_last = fill_last;
    status.slot_free = !oval_r || out_ready;
  end

  assign out_valid    = oval_r;
  assign out_value    = oval_data_r;
  assign out_position = opos_r;
  assign out_filled   = ofill_r;
  assign out_unfilled = ounf_r;
  assign out_last     = olast_r;

endmodule

>>> rtl/masked_gap_linear_fill.sv
// ----------------------------------------------------------------------------
// masked_gap_linear_fill: sinogram gap repair by linear interpolation
// Passes valid samples, holds back runs of masked samples and emits each
// held sample as a rounded linear blend of its neighbors when the run closes.
// ----------------------------------------------------------------------------
// The block works on one input transaction at a time. A valid sample with no
// open run passes through evaluation and an emit state that loads its result
// into the output register; a held masked sample passes through evaluation
// only. A run of held samples closed by a valid sample is handled as follows:
// the reciprocal of the run length plus one comes from a restoring divider at
// one quotient bit per cycle (17 steps, once per run), and each filled sample
// then takes a weight step, a multiply and an output load. Filled samples come
// out in ascending position with was_filled set, before the result of the
// input that closed the run; a masked sample beyond 63 in one run comes out as
// zero with unfilled set as soon as it is taken, or after the fills if it ends the row.
module masked_gap_linear_fill (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mglf_pkg::IN_DATA_W-1:0]      in_tdata,   // [23:0] sample_value
  input  logic [0:0]                          in_tuser,   // [0] masked
  input  logic                                in_tlast,   // row_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mglf_pkg::OUT_DATA_W-1:0]     out_tdata,  // [23:0] out_value, [35:24] position
  output logic [mglf_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] was_filled, [1] unfilled
  output logic                                out_tlast   // last
);

  mglf_pkg::cmd_t                         cmd;
  mglf_pkg::status_t                      status;
  logic signed [mglf_pkg::SAMPLE_W-1:0]   value;
  logic [mglf_pkg::POS_W-1:0]             position;
  logic                                   filled;
  logic                                   unfilled;

  mglf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mglf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_sample    ($signed(in_tdata[mglf_pkg::SAMPLE_W-1:0])),
    .in_masked    (in_tuser[0]),
    .in_row_end   (in_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (value),
    .out_position (position),
    .out_filled   (filled),
    .out_unfilled (unfilled),
    .out_last     (out_tlast)
  );

  assign out_tdata = {(mglf_pkg::OUT_DATA_W - mglf_pkg::SAMPLE_W - mglf_pkg::POS_W)'(0),
                      position, value};
  assign out_tuser = {unfilled, filled};

endmodule
